// File: sv/shss_pkg.sv
`timescale 1ns / 1ps

package shss_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int SPEED_BITS_DEF = 16;
    localparam int SPEED_RESET    = 10000;
    localparam int OUT_BYTES_W    = 8;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic [2:0] LAST_PHASE     = 3'd7;
    localparam logic [2:0] REV_FIRST_IDX  = 3'd6;
    localparam logic [3:0] COILS_OFF      = 4'b0000;

    // coil0 in bit 0
    localparam logic [3:0] HALF_STEP [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    function automatic logic [3:0] phase_pattern(input logic [2:0] phase, input logic rev);
        logic [2:0] idx;
        idx = rev ? 3'(REV_FIRST_IDX - phase) : phase;
        return HALF_STEP[idx];
    endfunction

endpackage

// File: sv/stepper_half_step_sequencer_core.sv
`timescale 1ns / 1ps

// Four-coil half-step sequencer. Each request on the input stream is a tick (tuser 0)
// or a start command (tuser 1) with a signed cycle count in tdata; each request gives
// exactly one result with the coil drive, the busy flag and a rejected flag. A request is
// taken every clock unless the output stalls: the state update and the result are formed
// combinationally from the accepted request and written into the state and output registers,
// so a result appears in the cycle after its request. s_axis_tready is low only while the
// output register holds a result that the sink has not yet taken. The speed register is
// written through i_cfg_wr_en / i_cfg_wr_data; speed / 8, at least 1, is latched as the phase dwell at start.
module stepper_half_step_sequencer_core #(
    parameter int COUNT_BITS = shss_pkg::COUNT_BITS_DEF,
    parameter int SPEED_BITS = shss_pkg::SPEED_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [SPEED_BITS-1:0]               i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // step_count
    input  logic [((COUNT_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // coils[3:0], busy_res, rejected, zero pad
    output logic [shss_pkg::OUT_BYTES_W-1:0]    m_axis_tdata
);

    localparam int DW = SPEED_BITS - 3;

    logic [SPEED_BITS-1:0] r_speed;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic                  r_rev, n_rev;
    logic [2:0]            r_phase, n_phase;
    logic [DW-1:0]         r_dwell_left, n_dwell_left;
    logic [DW-1:0]         r_dwell_len, n_dwell_len;
    logic                  r_running, n_running;
    logic                  r_off_tail, n_off_tail;
    logic [3:0]            r_coils, n_coils;
    logic                  n_rej;
    logic                  r_m_valid;
    logic [shss_pkg::OUT_BYTES_W-1:0] r_m_data;

    logic                  w_accept;
    logic [COUNT_BITS-1:0] w_count;
    logic                  w_neg;
    logic [COUNT_BITS-1:0] w_mag;
    logic [DW-1:0]         w_dwell;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign w_count = s_axis_tdata[COUNT_BITS-1:0];
    assign w_neg   = w_count[COUNT_BITS-1];
    // most negative count maps onto itself, which is the right magnitude
    assign w_mag   = w_neg ? (~w_count + 1'b1) : w_count;
    assign w_dwell = (r_speed[SPEED_BITS-1:3] == '0) ? DW'(1) : r_speed[SPEED_BITS-1:3];

    always_comb begin
        n_rem        = r_rem;
        n_rev        = r_rev;
        n_phase      = r_phase;
        n_dwell_left = r_dwell_left;
        n_dwell_len  = r_dwell_len;
        n_running    = r_running;
        n_off_tail   = r_off_tail;
        n_coils      = r_coils;
        n_rej        = 1'b0;
        if (w_accept) begin
            if (s_axis_tuser == shss_pkg::ACT_TICK) begin
                if (r_running) begin
                    if (r_dwell_left > DW'(1)) begin
                        n_dwell_left = r_dwell_left - 1'b1;
                    end else if (r_off_tail) begin
                        n_running    = 1'b0;
                        n_off_tail   = 1'b0;
                        n_dwell_left = '0;
                        n_coils      = shss_pkg::COILS_OFF;
                    end else if (r_phase != shss_pkg::LAST_PHASE) begin
                        n_phase      = r_phase + 1'b1;
                        n_coils      = shss_pkg::phase_pattern(r_phase + 1'b1, r_rev);
                        n_dwell_left = r_dwell_len;
                    end else if (r_rem != '0) begin
                        n_rem        = r_rem - 1'b1;
                        n_phase      = '0;
                        n_coils      = shss_pkg::phase_pattern(3'd0, r_rev);
                        n_dwell_left = r_dwell_len;
                    end else begin
                        n_off_tail   = 1'b1;
                        n_coils      = shss_pkg::COILS_OFF;
                        n_dwell_left = r_dwell_len;
                    end
                end
            end else if (r_running) begin
                n_rej = 1'b1;
            end else begin
                n_dwell_len  = w_dwell;
                n_dwell_left = w_dwell;
                n_running    = 1'b1;
                n_phase      = '0;
                n_rev        = w_neg;
                if (w_mag == '0) begin
                    n_off_tail = 1'b1;
                    n_rem      = '0;
                    n_coils    = shss_pkg::COILS_OFF;
                end else begin
                    n_off_tail = 1'b0;
                    n_rem      = w_mag - 1'b1;
                    n_coils    = shss_pkg::phase_pattern(3'd0, w_neg);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed      <= SPEED_BITS'(shss_pkg::SPEED_RESET);
            r_rem        <= '0;
            r_rev        <= 1'b0;
            r_phase      <= '0;
            r_dwell_left <= '0;
            r_dwell_len  <= '0;
            r_running    <= 1'b0;
            r_off_tail   <= 1'b0;
            r_coils      <= shss_pkg::COILS_OFF;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_speed <= i_cfg_wr_data;
            end
            r_rem        <= n_rem;
            r_rev        <= n_rev;
            r_phase      <= n_phase;
            r_dwell_left <= n_dwell_left;
            r_dwell_len  <= n_dwell_len;
            r_running    <= n_running;
            r_off_tail   <= n_off_tail;
            r_coils      <= n_coils;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= {(shss_pkg::OUT_BYTES_W-6)'(0), n_rej, n_running, n_coils};
        end
    end

endmodule

// File: sv/shss_chk.sv
`timescale 1ns / 1ps

module shss_chk #(
    parameter int COUNT_BITS = shss_pkg::COUNT_BITS_DEF,
    parameter int SPEED_BITS = shss_pkg::SPEED_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_wr_en,
    input logic [SPEED_BITS-1:0]            i_cfg_wr_data,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [((COUNT_BITS+7)/8)*8-1:0]  s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [shss_pkg::OUT_BYTES_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every accepted request yields a result next cycle
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    // a rejected start can only happen while busy
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("rejected while idle");

    // idle means coils off
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[3:0] == shss_pkg::COILS_OFF)
        else $error("coils driven while idle");

endmodule

bind stepper_half_step_sequencer_core shss_chk #(
    .COUNT_BITS(COUNT_BITS),
    .SPEED_BITS(SPEED_BITS)
) u_shss_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       rejected;
    } t_drive;

    localparam logic [3:0] FWD_TABLE [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };
    localparam int PHASES = 6;
    localparam int PHASE_SPEED [PHASES] = '{8, 7, 23, 0, 40, 12};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 83, 0, 9, 0, 0};
    localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 83, 9, 0, 83};

    class t_coil_sequence_board;
        logic [15:0] speed;
        logic [15:0] cycles_left;
        logic        rev;
        logic [2:0]  phase;
        logic [12:0] dwell_left;
        logic [12:0] dwell_len;
        logic        running;
        logic        off_tail;
        logic [3:0]  coils;
        t_drive      drive_q[$];
        int          errors;
        int          requests;
        int          starts;
        int          refused;

        function new();
            speed = 16'(shss_pkg::SPEED_RESET);
            cycles_left = '0;
            rev = 1'b0;
            phase = '0;
            dwell_left = '0;
            dwell_len = '0;
            running = 1'b0;
            off_tail = 1'b0;
            coils = shss_pkg::COILS_OFF;
            errors = 0;
            requests = 0;
            starts = 0;
            refused = 0;
        endfunction

        function logic [3:0] pattern(input logic [2:0] ph);
            return rev ? FWD_TABLE[3'(shss_pkg::REV_FIRST_IDX - ph)] : FWD_TABLE[ph];
        endfunction

        function void advance();
            if (!running)
                return;
            if (dwell_left > 13'd1) begin
                dwell_left--;
                return;
            end
            if (off_tail) begin
                running = 1'b0;
                off_tail = 1'b0;
                dwell_left = '0;
                coils = shss_pkg::COILS_OFF;
                return;
            end
            if (phase != shss_pkg::LAST_PHASE) begin
                phase++;
            end else if (cycles_left != 0) begin
                cycles_left--;
                phase = '0;
            end else begin
                // last cycle done: coils off for one more dwell
                off_tail = 1'b1;
                coils = shss_pkg::COILS_OFF;
                dwell_left = dwell_len;
                return;
            end
            coils = pattern(phase);
            dwell_left = dwell_len;
        endfunction

        function void begin_move(input logic [15:0] cnt);
            int mag;
            logic [15:0] d;
            mag = int'($signed(cnt));
            rev = (mag < 0);
            if (mag < 0)
                mag = -mag;
            d = speed >> 3;
            dwell_len = (d == 0) ? 13'd1 : d[12:0];
            dwell_left = dwell_len;
            running = 1'b1;
            phase = '0;
            starts++;
            if (mag == 0) begin
                off_tail = 1'b1;
                cycles_left = '0;
                coils = shss_pkg::COILS_OFF;
            end else begin
                off_tail = 1'b0;
                cycles_left = 16'(mag - 1);
                coils = pattern(3'd0);
            end
        endfunction

        function void take_request(input logic act, input logic [15:0] cnt);
            t_drive e;
            e.rejected = 1'b0;
            requests++;
            if (act == shss_pkg::ACT_TICK) begin
                advance();
            end else if (running) begin
                e.rejected = 1'b1;
                refused++;
            end else begin
                begin_move(cnt);
            end
            e.coils = coils;
            e.busy = running;
            drive_q.push_back(e);
        endfunction

        function void mismatch(input string what, input logic [3:0] exp_v,
                               input logic [3:0] got_v);
            errors++;
            if (errors <= 30)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
        endfunction

        function void check_drive(input logic [7:0] d);
            t_drive e;
            if (drive_q.size() == 0) begin
                errors++;
                if (errors <= 30)
                    $display("%0t: result %h with no request outstanding, expected none",
                             $time, d);
                return;
            end
            e = drive_q.pop_front();
            if (d[3:0] !== e.coils)
                mismatch("coils", e.coils, d[3:0]);
            if (d[4] !== e.busy)
                mismatch("busy", 4'(e.busy), 4'(d[4]));
            if (d[5] !== e.rejected)
                mismatch("rejected", 4'(e.rejected), 4'(d[5]));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // step_count
    logic        s_axis_tuser = shss_pkg::ACT_TICK;    // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;    // coils[3:0], busy_res, rejected, zero pad

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    t_coil_sequence_board board = new();

    stepper_half_step_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // sink side, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // handshakes sampled mid-cycle, where all signals are settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_drive(m_axis_tdata);
        end
    end

    task automatic send_item(input logic act, input logic [15:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= cnt;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.running)
            send_item(shss_pkg::ACT_TICK, 16'($urandom));
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.drive_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_speed(input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.speed = value;
    endtask

    task automatic run_random(input int target);
        int done_cnt;
        int mag;
        logic [15:0] cnt;
        done_cnt = 0;
        while (done_cnt < target) begin
            if (!board.running && $urandom_range(9) == 0) begin
                send_item(shss_pkg::ACT_TICK, 16'($urandom));
            end else if (board.running && $urandom_range(99) < 5) begin
                send_item(shss_pkg::ACT_START, 16'($urandom));
            end else if (board.running) begin
                send_item(shss_pkg::ACT_TICK, 16'($urandom));
                done_cnt++;
            end else begin
                mag = ($urandom_range(7) == 0) ? $urandom_range(6, 3) : $urandom_range(2);
                cnt = 16'(mag);
                if ($urandom_range(1) == 1)
                    cnt = -cnt;
                send_item(shss_pkg::ACT_START, cnt);
                done_cnt++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset period value, idle tick, zero count, start while busy
        send_item(shss_pkg::ACT_TICK, 16'hFFFF);
        send_item(shss_pkg::ACT_START, 16'h0000);
        send_item(shss_pkg::ACT_START, 16'h7FFF);
        drain();
        wait_results();

        set_speed(16'd8);
        send_item(shss_pkg::ACT_START, 16'h0000);
        send_item(shss_pkg::ACT_TICK, 16'h0000);
        send_item(shss_pkg::ACT_TICK, 16'h5A5A);
        send_item(shss_pkg::ACT_START, 16'h0001);
        send_item(shss_pkg::ACT_START, 16'h8000);
        drain();
        send_item(shss_pkg::ACT_START, 16'hFFFF);
        drain();
        send_item(shss_pkg::ACT_START, 16'h0002);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            drain();
            wait_results();
            set_speed(16'(PHASE_SPEED[p]));
            send_idle_pct = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            if (p == 0)
                hold_req = 300;
            run_random(15);
            if (p == 1)
                wait_results();
            run_random(15);
        end

        drain();
        wait_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests: %0d moves started, %0d starts refused while busy",
                 board.requests, board.starts, board.refused);
        $display("reset period dwell, short dwells, counts up to six cycles both directions");
        if (board.errors == 0)
            $display("stepper_half_step_sequencer_core test passed");
        else
            $display("stepper_half_step_sequencer_core test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting for the sequencer");
        $display("stepper_half_step_sequencer_core test failed");
        $finish;
    end

endmodule
